@@ hdl/nvbl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nvbl_pkg
// Shared types and codes for the NV12 buffer layout unit.
// ----------------------------------------------------------------------------
package nvbl_pkg;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;
    localparam logic [1:0] ST_SMALL    = 2'd3;

    localparam logic [1:0] REG_FRAME_WIDTH      = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT     = 2'd1;
    localparam logic [1:0] REG_WIDTH_ALIGNMENT  = 2'd2;
    localparam logic [1:0] REG_HEIGHT_ALIGNMENT = 2'd3;

    localparam int unsigned CFG_DATA_W = 17;
    localparam int unsigned DIM_W      = 17;

    typedef struct packed {
        logic [31:0] base_address;
        logic [31:0] capacity;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] line_stride;
        logic [31:0] line_bytes;
        logic [31:0] padded_height;
        logic [31:0] luma_bytes;
        logic [31:0] image_bytes;
        logic [31:0] luma_address;
        logic [31:0] chroma_address;
    } t_out_item;

    // Geometry derived from the configuration registers
    typedef struct packed {
        logic             invalid;
        logic [DIM_W-1:0] stride;
        logic [DIM_W-1:0] height;
    } t_geom;

    // Transaction between the sizing stage and the check stage
    typedef struct packed {
        t_in_item    item;
        t_geom       geom;
        logic [32:0] luma;
    } t_mid_item;

endpackage

@@ hdl/nv12_buffer_layout_unit.sv @@
`timescale 1ns / 1ps
// Throughput: one transaction per cycle while the output is not stalled.
// A transaction passes input, middle and result registers; the stride by height
// multiply sits alone between input and middle, the checks before the result.
// Reset: synchronous, active low; clears the pipeline valids and sets width and
// height to zero and both alignments to one.
// ----------------------------------------------------------------------------
// nv12_buffer_layout_unit
// NV12 frame buffer layout: plane sizes, addresses and buffer status.
// ----------------------------------------------------------------------------
module nv12_buffer_layout_unit import nvbl_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_in_item              i_item,
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_out_item             o_result
);

    t_geom     w_geom;
    t_mid_item w_mid;
    logic      w_mid_valid;
    logic      w_mid_stall;

    nvbl_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_geom      (w_geom)
    );

    nvbl_size_stage u_size (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .i_geom  (w_geom),
        .o_valid (w_mid_valid),
        .i_stall (w_mid_stall),
        .o_mid   (w_mid)
    );

    nvbl_check_stage u_check (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_mid_valid),
        .o_stall  (w_mid_stall),
        .i_mid    (w_mid),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (o_result)
    );

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall && w_mid_valid))
        else $error("input stalled while the pipeline has room");

    a_error_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status != ST_OK) |->
        (o_result.line_stride == '0 && o_result.luma_bytes == '0 &&
         o_result.image_bytes == '0 && o_result.chroma_address == '0 &&
         o_result.luma_address == '0 && o_result.padded_height == '0))
        else $error("error result carries nonzero data");

    a_chroma_follows_luma: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status == ST_OK) |->
        (o_result.chroma_address == o_result.luma_address + o_result.luma_bytes))
        else $error("chroma plane does not follow luma plane");

    a_image_ratio: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status == ST_OK) |->
        (o_result.image_bytes == o_result.luma_bytes + (o_result.luma_bytes >> 1)))
        else $error("image size is not one and a half luma sizes");
`endif

endmodule

@@ hdl/nvbl_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nvbl_cfg
// Configuration registers and the rounded-up frame geometry.
// ----------------------------------------------------------------------------
module nvbl_cfg import nvbl_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_geom                 o_geom
);

    logic [15:0]      r_frame_width;
    logic [15:0]      r_frame_height;
    logic [DIM_W-1:0] r_width_alignment;
    logic [DIM_W-1:0] r_height_alignment;
    logic [DIM_W-1:0] w_wa_m1;
    logic [DIM_W-1:0] w_ha_m1;
    logic             w_wa_pow2;
    logic             w_ha_pow2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width      <= '0;
            r_frame_height     <= '0;
            r_width_alignment  <= DIM_W'(1);
            r_height_alignment <= DIM_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FRAME_WIDTH:      r_frame_width      <= i_cfg_data[15:0];
                REG_FRAME_HEIGHT:     r_frame_height     <= i_cfg_data[15:0];
                REG_WIDTH_ALIGNMENT:  r_width_alignment  <= i_cfg_data;
                REG_HEIGHT_ALIGNMENT: r_height_alignment <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_wa_m1   = r_width_alignment - DIM_W'(1);
    assign w_ha_m1   = r_height_alignment - DIM_W'(1);
    assign w_wa_pow2 = (r_width_alignment != '0) && ((r_width_alignment & w_wa_m1) == '0);
    assign w_ha_pow2 = (r_height_alignment != '0) && ((r_height_alignment & w_ha_m1) == '0);

    // Round up by adding align-1 and clearing the low bits
    always_comb begin
        o_geom.invalid = (r_frame_width == '0) || (r_frame_height == '0) ||
                         !w_wa_pow2 || !w_ha_pow2;
        o_geom.stride  = (DIM_W'(r_frame_width) + w_wa_m1) & ~w_wa_m1;
        o_geom.height  = (DIM_W'(r_frame_height) + w_ha_m1) & ~w_ha_m1;
    end

endmodule

@@ hdl/nvbl_size_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nvbl_size_stage
// Input register, then the stride by height multiply into a middle register.
// ----------------------------------------------------------------------------
module nvbl_size_stage import nvbl_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_item,
    input  t_geom     i_geom,
    output logic      o_valid,
    input  logic      i_stall,
    output t_mid_item o_mid
);

    logic      r_in_valid;
    t_in_item  r_in_item;
    t_geom     r_in_geom;
    logic      r_mid_valid;
    t_mid_item r_mid;
    logic      w_mid_load;
    logic      w_in_load;

    assign w_mid_load = !(r_mid_valid && i_stall);
    assign w_in_load  = !(r_in_valid && !w_mid_load);
    assign o_stall    = !w_in_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_mid_valid <= 1'b0;
        end else begin
            if (w_in_load) begin
                r_in_valid <= i_valid;
            end
            if (w_mid_load) begin
                r_mid_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_load && i_valid) begin
            r_in_item <= i_item;
            r_in_geom <= i_geom;
        end
        if (w_mid_load && r_in_valid) begin
            r_mid.item <= r_in_item;
            r_mid.geom <= r_in_geom;
            // for a valid geometry both factors are at most 2^16, so the product fits 33 bits
            r_mid.luma <= 33'(r_in_geom.stride) * 33'(r_in_geom.height);
        end
    end

    assign o_valid = r_mid_valid;
    assign o_mid   = r_mid;

endmodule

@@ hdl/nvbl_check_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nvbl_check_stage
// Image size, status checks and plane addresses into the result register.
// ----------------------------------------------------------------------------
module nvbl_check_stage import nvbl_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_mid_item i_mid,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_result
);

    logic        r_valid;
    t_out_item   r_result;
    t_out_item   n_result;
    logic        w_load;
    logic [32:0] w_image;
    logic [33:0] w_end;

    assign w_load  = !(r_valid && i_stall);
    assign o_stall = !w_load;

    assign w_image = i_mid.luma + {1'b0, i_mid.luma[32:1]};
    assign w_end   = 34'(i_mid.item.base_address) + 34'(w_image);

    always_comb begin
        n_result = '0;
        if (i_mid.geom.invalid) begin
            n_result.status = ST_INVALID;
        end else if (w_image[32]) begin
            // image is never below luma, so one bit covers every size
            n_result.status = ST_OVERFLOW;
        end else if ({1'b0, i_mid.item.capacity} < w_image) begin
            n_result.status = ST_SMALL;
        end else if (w_end > 34'h1_0000_0000) begin
            n_result.status = ST_OVERFLOW;
        end else begin
            n_result.status         = ST_OK;
            n_result.line_stride    = 32'(i_mid.geom.stride);
            n_result.line_bytes     = 32'(i_mid.geom.stride) + 32'(i_mid.geom.stride >> 1);
            n_result.padded_height  = 32'(i_mid.geom.height);
            n_result.luma_bytes     = i_mid.luma[31:0];
            n_result.image_bytes    = w_image[31:0];
            n_result.luma_address   = i_mid.item.base_address;
            n_result.chroma_address = i_mid.item.base_address + i_mid.luma[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && i_valid) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

@@ verif/nv12_layout_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nv12_layout_checker
// Watches the register port and both channels of the NV12 buffer layout unit.
// Keeps a shadow of the geometry registers, predicts the layout of every
// accepted buffer descriptor and compares each result field by field, in order.
// ----------------------------------------------------------------------------
module nv12_layout_checker import nvbl_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_desc_valid,
    input  logic                  i_desc_stall,
    input  t_in_item              i_desc,
    input  logic                  i_layout_valid,
    input  logic                  i_layout_stall,
    input  t_out_item             i_layout,
    output int                    o_mismatches,
    output int                    o_pending
);

    localparam logic [63:0] LIMIT32        = 64'hFFFF_FFFF;
    localparam logic [63:0] BITS_PER_PIXEL = 64'd12;
    localparam int          REPORT_LIMIT   = 10;

    logic [15:0] frame_w;
    logic [15:0] frame_h;
    logic [16:0] align_w;
    logic [16:0] align_h;
    t_out_item   layout_q[$];

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    function automatic bit is_pow2(input logic [16:0] v);
        return (v != 0) && ((v & (v - 17'd1)) == 0);
    endfunction

    function automatic logic [63:0] align_up(input logic [63:0] v, input logic [63:0] a);
        return (v + a - 64'd1) & ~(a - 64'd1);
    endfunction

    function automatic t_out_item predict_layout(input t_in_item desc);
        logic [63:0] stride;
        logic [63:0] height;
        logic [63:0] line;
        logic [63:0] luma;
        logic [63:0] image;
        t_out_item   lay;
        lay = '0;
        if (frame_w == 0 || frame_h == 0 || !is_pow2(align_w) || !is_pow2(align_h)) begin
            lay.status = ST_INVALID;
            return lay;
        end
        stride = align_up(64'(frame_w), 64'(align_w));
        height = align_up(64'(frame_h), 64'(align_h));
        line   = (stride * BITS_PER_PIXEL) >> 3;
        luma   = stride * height;
        image  = luma + (luma >> 1);
        if (stride > LIMIT32 || line > LIMIT32 || height > LIMIT32 ||
            luma > LIMIT32 || image > LIMIT32) begin
            lay.status = ST_OVERFLOW;
        end else if (64'(desc.capacity) < image) begin
            lay.status = ST_SMALL;
        end else if (64'(desc.base_address) + image - 64'd1 > LIMIT32) begin
            lay.status = ST_OVERFLOW;
        end else begin
            lay.status         = ST_OK;
            lay.line_stride    = stride[31:0];
            lay.line_bytes     = line[31:0];
            lay.padded_height  = height[31:0];
            lay.luma_bytes     = luma[31:0];
            lay.image_bytes    = image[31:0];
            lay.luma_address   = desc.base_address;
            lay.chroma_address = desc.base_address + luma[31:0];
        end
        return lay;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            if (o_mismatches < REPORT_LIMIT)
                $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
            o_mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : track
        t_out_item want;
        if (!i_rst_n) begin
            frame_w = '0;
            frame_h = '0;
            align_w = 17'd1;
            align_h = 17'd1;
            layout_q.delete();
        end else begin
            // compare before pushing: a result never belongs to this cycle's descriptor
            if (i_layout_valid && !i_layout_stall) begin
                if (layout_q.size() == 0) begin
                    if (o_mismatches < REPORT_LIMIT)
                        $display("%0t: layout result with none expected: %h", $time, i_layout);
                    o_mismatches++;
                end else begin
                    want = layout_q.pop_front();
                    check_field("status", 32'(want.status), 32'(i_layout.status));
                    check_field("line_stride", want.line_stride, i_layout.line_stride);
                    check_field("line_bytes", want.line_bytes, i_layout.line_bytes);
                    check_field("padded_height", want.padded_height, i_layout.padded_height);
                    check_field("luma_bytes", want.luma_bytes, i_layout.luma_bytes);
                    check_field("image_bytes", want.image_bytes, i_layout.image_bytes);
                    check_field("luma_address", want.luma_address, i_layout.luma_address);
                    check_field("chroma_address", want.chroma_address,
                                i_layout.chroma_address);
                end
            end
            if (i_desc_valid && !i_desc_stall)
                layout_q.push_back(predict_layout(i_desc));
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_FRAME_WIDTH:      frame_w = i_cfg_data[15:0];
                    REG_FRAME_HEIGHT:     frame_h = i_cfg_data[15:0];
                    REG_WIDTH_ALIGNMENT:  align_w = i_cfg_data[16:0];
                    REG_HEIGHT_ALIGNMENT: align_h = i_cfg_data[16:0];
                    default: ;
                endcase
            end
        end
        o_pending = layout_q.size();
    end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives buffer descriptors and geometry settings into the NV12 buffer layout
// unit: directed corner cases first, then random geometries and descriptors
// under several sender and receiver idle patterns and one long receiver hold.
// ----------------------------------------------------------------------------
module tb_top;
    import nvbl_pkg::*;

    localparam int          CLK_HALF           = 6;
    localparam int          RESET_CYCLES       = 7;
    localparam int          IDLE_LIMIT         = 2000;
    localparam int          HOLD_CYCLES        = 200;
    localparam int          ITEMS_PER_GEOMETRY = 40;
    localparam int          SETTLE_CYCLES      = 8;
    localparam logic [63:0] ADDR_SPACE         = 64'h1_0000_0000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [1:0]            i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_stall;
    t_in_item              i_item;
    logic                  o_valid;
    logic                  i_stall;
    t_out_item             o_result;

    int          mismatches;
    int          pending;
    int unsigned idle_pct     = 0;
    int unsigned stall_pct    = 0;
    bit          hold_req     = 1'b0;
    int          quiet_cycles = 0;
    logic [63:0] image_hint   = '0;

    nv12_buffer_layout_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_result    (o_result)
    );

    nv12_layout_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_desc_valid   (i_valid),
        .i_desc_stall   (o_stall),
        .i_desc         (i_item),
        .i_layout_valid (o_valid),
        .i_layout_stall (i_stall),
        .i_layout       (o_result),
        .o_mismatches   (mismatches),
        .o_pending      (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Receiver: random stalls, or one long hold when requested
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                i_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input t_in_item desc);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= desc;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic set_geometry(input logic [16:0] w, input logic [16:0] h,
                                input logic [16:0] aw, input logic [16:0] ah);
        logic [63:0] sw;
        logic [63:0] sh;
        wait_drained();
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_WIDTH_ALIGNMENT, aw);
        write_reg(REG_HEIGHT_ALIGNMENT, ah);
        // rough image size, only used to aim descriptors at the capacity and end limits
        sw = (aw == 0) ? 64'd0 : (64'(w[15:0]) + 64'(aw) - 64'd1) / 64'(aw) * 64'(aw);
        sh = (ah == 0) ? 64'd0 : (64'(h[15:0]) + 64'(ah) - 64'd1) / 64'(ah) * 64'(ah);
        image_hint = sw * sh + (sw * sh) / 2;
    endtask

    task automatic random_geometry();
        logic [16:0] w;
        logic [16:0] h;
        logic [16:0] aw;
        logic [16:0] ah;
        if ($urandom_range(4) == 0) begin
            w = 17'($urandom);
            h = 17'($urandom);
        end else begin
            w = 17'($urandom_range(2048, 1));
            h = 17'($urandom_range(2048, 1));
        end
        aw = 17'd1 << $urandom_range(($urandom_range(3) == 0) ? 16 : 6);
        ah = 17'd1 << $urandom_range(($urandom_range(3) == 0) ? 16 : 6);
        case ($urandom_range(11))
            0:       aw = 17'($urandom);
            1:       ah = 17'($urandom);
            2:       h = {1'($urandom_range(1)), 16'd0};
            default: ;
        endcase
        set_geometry(w, h, aw, ah);
    endtask

    function automatic t_in_item random_desc();
        t_in_item    desc;
        logic [63:0] room;
        desc.base_address = $urandom;
        desc.capacity     = $urandom;
        if (image_hint != 0 && image_hint < ADDR_SPACE) begin
            // highest base that keeps the end address in range
            room = ADDR_SPACE - image_hint;
            case ($urandom_range(9))
                0, 1, 2, 3, 4: begin
                    desc.capacity     = 32'(image_hint + 64'($urandom_range(4096)));
                    desc.base_address = 32'(64'($urandom) % (room + 64'd1));
                end
                5: desc.capacity = 32'(image_hint - 64'd1);
                6: begin
                    desc.capacity     = 32'(image_hint);
                    desc.base_address = 32'(room + 64'($urandom_range(1)));
                end
                default: ;
            endcase
        end
        return desc;
    endfunction

    initial begin : stimulus
        int mode;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_valid     = 1'b0;
        i_item      = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset geometry has zero dimensions
        send_item({32'h0, 32'h0});
        send_item({32'hFFFF_FFFF, 32'hFFFF_FFFF});

        set_geometry(17'd1920, 17'd1080, 17'd16, 17'd16);
        send_item({32'h0, 32'(image_hint)});
        send_item({32'h0, 32'(image_hint - 64'd1)});
        send_item({32'h0, 32'h0});
        send_item({32'hFFFF_FFFF, 32'hFFFF_FFFF});
        send_item({32'(ADDR_SPACE - image_hint), 32'(image_hint)});
        send_item({32'(ADDR_SPACE - image_hint + 64'd1), 32'hFFFF_FFFF});

        // smallest frame; last one wraps the chroma address to zero
        set_geometry(17'd1, 17'd1, 17'd1, 17'd1);
        send_item({32'h0, 32'd1});
        send_item({32'h0, 32'h0});
        send_item({32'hFFFF_FFFF, 32'd1});

        // odd stride and odd luma size truncate the halves
        set_geometry(17'd3, 17'd5, 17'd1, 17'd1);
        send_item({32'h1234_5678, 32'd22});

        // largest alignments: luma reaches 2^32; bit 16 of width data is dropped
        set_geometry(17'h1FFFF, 17'd65535, 17'd65536, 17'd65536);
        send_item({32'h0, 32'hFFFF_FFFF});
        set_geometry(17'd65535, 17'd65535, 17'd1, 17'd1);
        send_item({32'h0, 32'hFFFF_FFFF});
        set_geometry(17'd65535, 17'd1, 17'd65536, 17'd1);
        send_item({32'h0, 32'hFFFF_FFFF});

        // invalid settings
        set_geometry(17'd0, 17'd5, 17'd1, 17'd1);
        send_item({32'h0, 32'hFFFF_FFFF});
        set_geometry(17'd5, 17'h10000, 17'd1, 17'd1);
        send_item({32'h0, 32'hFFFF_FFFF});
        set_geometry(17'd5, 17'd5, 17'd0, 17'd1);
        send_item({32'h0, 32'hFFFF_FFFF});
        set_geometry(17'd5, 17'd5, 17'd3, 17'd1);
        send_item({32'h0, 32'hFFFF_FFFF});
        set_geometry(17'd5, 17'd5, 17'd1, 17'h1FFFF);
        send_item({32'h0, 32'hFFFF_FFFF});

        for (mode = 0; mode < 4; mode++) begin
            case (mode)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 87; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 87; end
                default: begin idle_pct = 35; stall_pct = 35; end
            endcase
            repeat (3) begin
                random_geometry();
                repeat (ITEMS_PER_GEOMETRY) send_item(random_desc());
            end
        end

        // hold the receiver so the pipeline fills and backs up into the input
        idle_pct  = 0;
        stall_pct = 0;
        random_geometry();
        hold_req = 1'b1;
        repeat (ITEMS_PER_GEOMETRY) send_item(random_desc());

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ nv12_buffer_layout_unit.f @@
hdl/nvbl_pkg.sv
hdl/nvbl_cfg.sv
hdl/nvbl_size_stage.sv
hdl/nvbl_check_stage.sv
hdl/nv12_buffer_layout_unit.sv
verif/nv12_layout_checker.sv
verif/tb_top.sv
